/* rtl/core/sts_pkg.sv */
// shared constants, types and codes for the sorted table search block
// no dependencies; every other file of the block imports this package
package sts_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int SRCH_W      = IDX_W + 1;
  localparam int CNT_W       = 11;
  localparam int ADDR_W      = 10;
  localparam int KEY_W       = 32;
  localparam int POS_W       = 10;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [PADDR_W-3:0] REG_ENTRY_COUNT = '0;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_MISS  = 2'd2
  } item_kind_t;

  typedef struct packed {
    item_kind_t          kind;
    logic [IDX_W-1:0]    idx;
    logic [KEY_W-1:0]    key;
    logic [SRCH_W-1:0]   count;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

/* rtl/core/sts_front.sv */
// front end: config register, command intake and classification
// depends on sts_pkg
module sts_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sts_pkg::PADDR_W-1:0] paddr,
  input  logic [sts_pkg::PDATA_W-1:0] pwdata,
  output logic [sts_pkg::PDATA_W-1:0] prdata,
  input  logic                        start,
  input  logic                        opcode,
  input  logic [sts_pkg::ADDR_W-1:0]  address,
  input  logic [sts_pkg::KEY_W-1:0]   key_value,
  input  sts_pkg::queue_status_t      q_status,
  output logic                        push,
  output sts_pkg::item_t              push_item
);
  import sts_pkg::*;

  logic [CNT_W-1:0]  entry_count;
  logic [SRCH_W-1:0] clamped_count;
  logic              cfg_write;
  logic              write_in_range;

  assign cfg_write = psel && penable && pwrite &&
                     (paddr[PADDR_W-1:2] == REG_ENTRY_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_write) begin
      entry_count <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = PDATA_W'(entry_count);

  // counts past the table are searched as a full table
  always_comb begin
    if (int'(entry_count) > TABLE_DEPTH) begin
      clamped_count = SRCH_W'(TABLE_DEPTH);
    end else begin
      clamped_count = SRCH_W'(entry_count);
    end
  end

  assign write_in_range = int'(address) < TABLE_DEPTH;

  always_comb begin
    push_item.idx   = IDX_W'(address);
    push_item.key   = key_value;
    push_item.count = clamped_count;
    if (opcode == OP_WRITE) begin
      push_item.kind = KIND_WRITE;
    end else if (clamped_count == '0) begin
      push_item.kind = KIND_MISS;
    end else begin
      push_item.kind = KIND_QUERY;
    end
  end

  // out of range writes are dropped here
  assign push = start && !q_status.full &&
                ((opcode == OP_QUERY) || write_in_range);

endmodule

/* rtl/core/sts_queue.sv */
// small word queue between the front end and the search engine
// depends on sts_pkg
module sts_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  sts_pkg::item_t         push_item,
  input  logic                   pop,
  output sts_pkg::item_t         head,
  output sts_pkg::queue_status_t status
);
  import sts_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (int'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (int'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  assign head         = slots[rd_ptr];
  assign status.full  = int'(fill) == QUEUE_DEPTH;
  assign status.empty = fill == '0;

endmodule

/* rtl/core/sts_back.sv */
// search engine: table memory and the probe sequencer
// depends on sts_pkg
module sts_back (
  input  logic                      clk,
  input  logic                      rst,
  input  sts_pkg::queue_status_t    q_status,
  input  sts_pkg::item_t            head,
  output logic                      pop,
  output logic                      done,
  output logic                      found,
  output logic [sts_pkg::POS_W-1:0] position
);
  import sts_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_PROBE = 2'b10
  } state_t;

  state_t            state, state_next;
  logic [KEY_W-1:0]  table_mem [TABLE_DEPTH];
  logic [KEY_W-1:0]  rdata;
  logic [KEY_W-1:0]  key, key_next;
  logic [IDX_W-1:0]  base, base_next;
  logic [SRCH_W-1:0] n, n_next;
  logic [IDX_W-1:0]  mid, mid_next;
  logic              mem_we;
  logic              rd_en;
  logic              done_next;
  logic              found_next;
  logic [POS_W-1:0]  position_next;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[head.idx] <= head.key;
    end
    if (rd_en) begin
      rdata <= table_mem[mid_next];
    end
  end

  always_comb begin
    state_next    = state;
    key_next      = key;
    base_next     = base;
    n_next        = n;
    mid_next      = mid;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    pop           = 1'b0;
    done_next     = 1'b0;
    found_next    = 1'b0;
    position_next = '0;
    unique case (state)
      S_IDLE: begin
        if (!q_status.empty) begin
          pop = 1'b1;
          case (head.kind)
            KIND_WRITE: begin
              mem_we = 1'b1;
            end
            KIND_QUERY: begin
              key_next   = head.key;
              base_next  = '0;
              n_next     = head.count;
              mid_next   = IDX_W'(head.count >> 1);
              rd_en      = 1'b1;
              state_next = S_PROBE;
            end
            KIND_MISS: begin
              done_next = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_PROBE: begin
        if (rdata == key) begin
          done_next     = 1'b1;
          found_next    = 1'b1;
          position_next = POS_W'(mid);
          state_next    = S_IDLE;
        end else if (n == SRCH_W'(1)) begin
          // single entry window that misses
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else if (rdata > key) begin
          n_next   = n >> 1;
          mid_next = base + IDX_W'(n_next >> 1);
          rd_en    = 1'b1;
        end else begin
          base_next = mid;
          n_next    = n - (n >> 1);
          mid_next  = mid + IDX_W'(n_next >> 1);
          rd_en     = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    key      <= key_next;
    base     <= base_next;
    n        <= n_next;
    mid      <= mid_next;
    found    <= found_next;
    position <= position_next;
  end

endmodule

/* rtl/core/sorted_table_binary_search_top.sv */
// top level of the sorted table search block
// depends on sts_pkg, sts_front, sts_queue and sts_back
//
// the block keeps a table of 1024 ascending 32-bit unsigned words and
// answers lookups by binary search. a command word is taken on a clock edge
// with start high and busy low; opcode 0 stores key_value at address and
// gives no result, opcode 1 searches the first entry_count entries for
// key_value. each query gives exactly one result: done is high for a single
// cycle with found and position, and the receiver cannot hold it off, so it
// must take every result as it comes. position is 0 when nothing matches.
// a write is stored by the search engine from its idle state. a query is
// issued from the idle state, which reads the middle entry, and then probes
// in the probe state; each probe is one read of the table memory and one
// compare, and the probe count is at most ceil(log2(entry_count)) + 1. the
// engine pops nothing during a query. a two word queue sits between intake
// and the search engine, so busy only rises when two commands are waiting.
// entry_count is at byte address 0 of the apb port, keeps and reads back
// the low 11 bits written, and counts above 1024 search the whole table.
// change it only while no query is in flight. table entries are not cleared
// by reset: write every entry that a query may touch before searching.
module sorted_table_binary_search_top (
  input  logic                        clk,
  input  logic                        rst,
  // apb config port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sts_pkg::PADDR_W-1:0] paddr,
  input  logic [sts_pkg::PDATA_W-1:0] pwdata,
  output logic [sts_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  // command word
  input  logic                        start,
  output logic                        busy,
  input  logic                        opcode,
  input  logic [sts_pkg::ADDR_W-1:0]  address,
  input  logic [sts_pkg::KEY_W-1:0]   key_value,
  // result word
  output logic                        done,
  output logic                        found,
  output logic [sts_pkg::POS_W-1:0]   position
);
  import sts_pkg::*;

  queue_status_t q_status;
  item_t         push_item;
  item_t         head;
  logic          push;
  logic          pop;

  // the register file never waits
  assign pready = 1'b1;

  // busy only reflects a full queue
  assign busy = q_status.full;

  // intake, config register and classification
  sts_front u_front (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .start     (start),
    .opcode    (opcode),
    .address   (address),
    .key_value (key_value),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  // decouples intake from the search engine
  sts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  // table memory and probe sequencer
  sts_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .head     (head),
    .pop      (pop),
    .done     (done),
    .found    (found),
    .position (position)
  );

endmodule

/* rtl/core/sts_checker.sv */
// port level checks for the sorted table search block, bound to the top
// depends on sts_pkg and sorted_table_binary_search_top
module sts_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [sts_pkg::PADDR_W-1:0] paddr,
  input logic [sts_pkg::PDATA_W-1:0] pwdata,
  input logic [sts_pkg::PDATA_W-1:0] prdata,
  input logic                        pready,
  input logic                        busy,
  input logic                        done,
  input logic                        found,
  input logic [sts_pkg::POS_W-1:0]   position
);
  import sts_pkg::*;

  // reset leaves no result pending and the queue open
  a_reset_quiet: assert property (@(posedge clk) rst |=> (!done && !busy))
    else $error("result or busy right after reset");

  // a miss reports position zero
  a_miss_pos: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (position == '0))
    else $error("miss with nonzero position");

  // a hit lies inside the searched entries
  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (CNT_W'(position) < prdata[CNT_W-1:0]))
    else $error("hit outside the searched entries");

  // a config write lands in the count register
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && (paddr[PADDR_W-1:2] == REG_ENTRY_COUNT))
    |=> (prdata[CNT_W-1:0] == $past(pwdata[CNT_W-1:0])))
    else $error("entry count not updated by write");

endmodule

bind sorted_table_binary_search_top sts_checker u_sts_checker (.*);
